// ----- design/u8v_pkg.sv -----
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared types and constants of the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

    // longest UTF-8 sequence, and the widths that follow from it
    localparam int MaxSeqBytes = 4;
    localparam int SeqIdxW     = $clog2(MaxSeqBytes);
    localparam int CntW        = $clog2(MaxSeqBytes + 2);

    // job queue between front and back
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // output budget per piece after reset
    localparam logic [15:0] CapReset = 16'd4096;

    // input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       piece_end;
    } t_in;

    // result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       piece_done;
        logic       piece_ok;
        logic       failed;
    } t_out;

    // work handed from front to back: one entry per item that gives results
    typedef struct packed {
        logic [MaxSeqBytes-1:0][7:0] bytes;
        logic [CntW-1:0]             n_bytes;
        logic                        piece_end;
        logic                        failed;
    } t_job;

endpackage

// ----- design/utf8_stream_validator.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Strict UTF-8 stream checker: gathers sequences, checks them, re-emits them
// under a per-piece output budget and reports a status at each piece end.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_ready    i_in_data  (t_in)
// out      output     o_out_valid / i_out_ready  o_out_data (t_out)
// cfg      input      i_cfg_we                   i_cfg_data (out_capacity)
//
// An item is accepted each cycle while the four-entry job queue has room.
// The back gives one result a cycle while the output is not stalled: an item
// completing an n-byte sequence gives n results, a status-only item one.
// Reset restores all control state directly (the budget to CapReset); no clearing pass.
// Output stalls back up through the queue; the front stalls only when full.
// ----------------------------------------------------------------------------
module utf8_stream_validator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  u8v_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output u8v_pkg::t_out  o_out_data
);
    import u8v_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_job q_in_job;
    t_job q_head;

    // classification and sequence state
    u8v_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_job    (q_in_job)
    );

    // job queue
    u8v_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // result expansion
    u8v_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- design/u8v_front.sv -----
// ----------------------------------------------------------------------------
// u8v_front
// Accepts input bytes, gathers UTF-8 sequences, applies the strict checks
// and the per-piece budget, and queues a job for each item that gives results.
// ----------------------------------------------------------------------------
module u8v_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  u8v_pkg::t_in   i_in_data,
    input  logic           i_q_full,
    output logic           o_q_push,
    output u8v_pkg::t_job  o_q_job
);
    import u8v_pkg::*;

    // byte range limits
    localparam logic [7:0] ContLo  = 8'h80;
    localparam logic [7:0] ContHi  = 8'hbf;
    localparam logic [7:0] Lead2Lo = 8'hc2;
    localparam logic [7:0] Lead2Hi = 8'hdf;
    localparam logic [7:0] Lead3Lo = 8'he0;
    localparam logic [7:0] Lead3Hi = 8'hef;
    localparam logic [7:0] Lead4Lo = 8'hf0;
    localparam logic [7:0] Lead4Hi = 8'hf4;
    localparam logic [7:0] LeadE0  = 8'he0;
    localparam logic [7:0] LeadED  = 8'hed;
    localparam logic [7:0] LeadF0  = 8'hf0;
    localparam logic [7:0] LeadF4  = 8'hf4;
    localparam logic [7:0] MinE0   = 8'ha0;
    localparam logic [7:0] MaxED   = 8'h9f;
    localparam logic [7:0] MinF0   = 8'h90;
    localparam logic [7:0] MaxF4   = 8'h8f;

    // sequence length from lead byte, zero for a bad lead
    function automatic logic [CntW-1:0] lead_len(input logic [7:0] c);
        logic [CntW-1:0] len;
        len = '0;
        if (c < ContLo)                        len = CntW'(1);
        else if (c >= Lead2Lo && c <= Lead2Hi) len = CntW'(2);
        else if (c >= Lead3Lo && c <= Lead3Hi) len = CntW'(3);
        else if (c >= Lead4Lo && c <= Lead4Hi) len = CntW'(4);
        return len;
    endfunction

    // continuation check; tighter second-byte ranges after some leads
    function automatic logic cont_ok(input logic [7:0] c, input logic [7:0] lead,
                                     input logic second);
        logic ok;
        ok = (c >= ContLo) && (c <= ContHi);
        if (second) begin
            if (lead == LeadE0 && c < MinE0) ok = 1'b0;
            if (lead == LeadED && c > MaxED) ok = 1'b0;
            if (lead == LeadF0 && c < MinF0) ok = 1'b0;
            if (lead == LeadF4 && c > MaxF4) ok = 1'b0;
        end
        return ok;
    endfunction

    logic [15:0]                 r_cap;
    logic [MaxSeqBytes-1:0][7:0] r_held, n_held;
    logic [CntW-1:0]             r_held_cnt, n_held_cnt;
    logic [CntW-1:0]             r_need_cnt, n_need_cnt;
    logic                        r_failed, n_failed;
    logic [15:0]                 r_written, n_written;

    logic            accept;
    logic [7:0]      c;
    logic [CntW-1:0] need_eff;
    logic [CntW-1:0] cnt_new;
    logic            bad;
    logic            complete;
    logic            overrun;
    logic [CntW-1:0] emit_n;
    logic [16:0]     sum_ext;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign c          = i_in_data.data_byte;

    // classify the byte against what is held
    always_comb begin
        need_eff = (r_held_cnt == '0) ? lead_len(c) : r_need_cnt;
        if (r_held_cnt == '0) begin
            bad = (need_eff == '0);
        end else begin
            bad = !cont_ok(c, r_held[0], r_held_cnt == CntW'(1));
        end
        if (r_held_cnt >= CntW'(MaxSeqBytes)) bad = 1'b1;
        cnt_new  = r_held_cnt + CntW'(1);
        complete = (cnt_new == need_eff);
        sum_ext  = {1'b0, r_written} + 17'(cnt_new);
        overrun  = sum_ext >= {1'b0, r_cap};
    end

    // state update for an accepted item
    always_comb begin
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_need_cnt = r_need_cnt;
        n_failed   = r_failed;
        n_written  = r_written;
        emit_n     = '0;
        if (accept && !r_failed) begin
            if (bad) begin
                n_failed = 1'b1;
            end else begin
                n_held[r_held_cnt[SeqIdxW-1:0]] = c;
                n_held_cnt = cnt_new;
                n_need_cnt = need_eff;
                if (complete) begin
                    if (overrun) begin
                        n_failed = 1'b1;
                    end else begin
                        n_written  = sum_ext[15:0];
                        n_held_cnt = '0;
                        n_need_cnt = '0;
                        emit_n     = cnt_new;
                    end
                end
            end
        end
        if (accept && i_in_data.piece_end) n_written = '0;
    end

    // job to the queue
    assign o_q_push          = accept && (emit_n != '0 || i_in_data.piece_end);
    assign o_q_job.bytes     = n_held;
    assign o_q_job.n_bytes   = emit_n;
    assign o_q_job.piece_end = i_in_data.piece_end;
    assign o_q_job.failed    = n_failed;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CapReset;
            r_held_cnt <= '0;
            r_need_cnt <= '0;
            r_failed   <= 1'b0;
            r_written  <= '0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            r_held_cnt <= n_held_cnt;
            r_need_cnt <= n_need_cnt;
            r_failed   <= n_failed;
            r_written  <= n_written;
        end
    end

    // held bytes: payload, no reset
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

endmodule

// ----- design/u8v_fifo.sv -----
// ----------------------------------------------------------------------------
// u8v_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module u8v_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  u8v_pkg::t_job  i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output u8v_pkg::t_job  o_head
);
    import u8v_pkg::*;

    t_job             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCntW'(QDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + QPtrW'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + QPtrW'(1);
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCntW'(1);
                2'b01:   r_count <= r_count - QCntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_job;
    end

endmodule

// ----- design/u8v_back.sv -----
// ----------------------------------------------------------------------------
// u8v_back
// Expands the job at the queue head into result items, one a cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module u8v_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  u8v_pkg::t_job  i_q_head,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output u8v_pkg::t_out  o_out_data
);
    import u8v_pkg::*;

    logic [SeqIdxW-1:0] r_k;
    logic               r_out_valid;
    t_out               r_out, n_out;

    logic            load;
    logic [CntW-1:0] total;
    logic [CntW-1:0] k_ext;
    logic            is_last;
    logic            has_byte;

    // a slot is free when empty or its result leaves this cycle
    assign load = !i_q_empty && (!r_out_valid || i_out_ready);

    // build result k of the head job
    always_comb begin
        total    = (i_q_head.n_bytes == '0) ? CntW'(1) : i_q_head.n_bytes;
        k_ext    = CntW'(r_k);
        is_last  = (k_ext + CntW'(1)) == total;
        has_byte = k_ext < i_q_head.n_bytes;
        n_out.out_byte   = has_byte ? i_q_head.bytes[r_k] : 8'h00;
        n_out.byte_valid = has_byte;
        n_out.last       = is_last;
        n_out.piece_done = is_last && i_q_head.piece_end;
        n_out.piece_ok   = is_last && i_q_head.piece_end && !i_q_head.failed;
        n_out.failed     = i_q_head.failed;
    end

    assign o_q_pop     = load && is_last;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // result index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_k         <= is_last ? '0 : r_k + SeqIdxW'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) r_out <= n_out;
    end

endmodule

// ----- design/u8v_checker.sv -----
// ----------------------------------------------------------------------------
// u8v_checker
// Port-level checks on the validator's result stream.
// ----------------------------------------------------------------------------
module u8v_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           o_out_valid,
    input  logic           i_out_ready,
    input  u8v_pkg::t_out  o_out_data
);
    import u8v_pkg::*;

    logic r_seen_fail;

    // a failure once delivered stays set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_fail <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_out_data.failed) begin
            r_seen_fail <= 1'b1;
        end
    end

    // a result without a byte is always a piece status
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.byte_valid |->
            o_out_data.last && o_out_data.piece_done)
        else $error("status-only result not last piece end");

    // piece accepted only on a piece end of an unfailed stream
    a_piece_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.piece_ok |->
            o_out_data.piece_done && o_out_data.last && !o_out_data.failed)
        else $error("piece_ok without clean piece end");

    // sticky failure
    a_sticky_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_fail |-> o_out_data.failed)
        else $error("failure flag cleared");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind utf8_stream_validator u8v_checker u_chk (.*);
